// File: design/u8cjk_pkg.sv
// Package for the UTF-8 scanner: field widths, byte masks and CJK/Hangul range check.
package u8cjk_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 21;
  localparam int unsigned PendW = 2;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [PendW-1:0] pend_t;

  // Lead byte class masks and their match values.
  localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Val   = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Val   = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Val   = 8'hF0;
  localparam logic [ByteW-1:0] ContMask   = 8'hC0;
  localparam logic [ByteW-1:0] ContVal    = 8'h80;

  localparam pend_t PendOne   = 2'd1;
  localparam pend_t PendTwo   = 2'd2;
  localparam pend_t PendThree = 2'd3;

  // Inclusive CJK / Hangul ranges.
  localparam code_t CjkExtALo  = 21'h03400;
  localparam code_t CjkExtAHi  = 21'h09FFF;
  localparam code_t CjkCompLo  = 21'h0F900;
  localparam code_t CjkCompHi  = 21'h0FAFF;
  localparam code_t CjkExtBLo  = 21'h20000;
  localparam code_t CjkExtBHi  = 21'h2EBEF;
  localparam code_t CjkPunctLo = 21'h03000;
  localparam code_t CjkPunctHi = 21'h0303F;
  localparam code_t HalfFullLo = 21'h0FF00;
  localparam code_t HalfFullHi = 21'h0FFEF;
  localparam code_t JamoLo     = 21'h01100;
  localparam code_t JamoHi     = 21'h011FF;
  localparam code_t CompJamoLo = 21'h03130;
  localparam code_t CompJamoHi = 21'h0318F;
  localparam code_t HangulLo   = 21'h0AC00;
  localparam code_t HangulHi   = 21'h0D7AF;

  function automatic logic in_cjk_range(input code_t c);
    in_cjk_range = (c >= CjkExtALo  && c <= CjkExtAHi)
                || (c >= CjkCompLo  && c <= CjkCompHi)
                || (c >= CjkExtBLo  && c <= CjkExtBHi)
                || (c >= CjkPunctLo && c <= CjkPunctHi)
                || (c >= HalfFullLo && c <= HalfFullHi)
                || (c >= JamoLo     && c <= JamoHi)
                || (c >= CompJamoLo && c <= CompJamoHi)
                || (c >= HangulLo   && c <= HangulHi);
  endfunction

endpackage

// File: design/utf8_scan_cjk_detect_unit.sv
// UTF-8 text scanner that reports ASCII-only, first multibyte codepoint and first CJK codepoint.
// Result: the result of a text appears in the cycle after its end-of-text byte leaves the
// input register; that byte waits there while a result is still held at the output.
// Throughput: one byte per cycle; the byte register feeds the decode logic and the result
// register, and only an end-of-text byte waits on a result still held at the output.
// Reset: synchronous, active low; clears the decode state and all valid flags.
module utf8_scan_cjk_detect_unit
  import u8cjk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_text_byte,
  input  logic             in_end_of_text,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_ascii_only,
  output logic             out_non_ascii_found,
  output logic [CodeW-1:0] out_non_ascii_code,
  output logic             out_cjk_found,
  output logic [CodeW-1:0] out_cjk_code
);

  // Input register.
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_eot_r;
  logic             s1_adv;

  // Decode state.
  pend_t pending_r,     pending_nxt;
  code_t asm_r,         asm_nxt;
  logic  saw_high_r,    saw_high_nxt;
  logic  first_over_r,  first_over_nxt;
  logic  first_hit_r,   first_hit_nxt;
  code_t first_val_r,   first_val_nxt;
  logic  cjk_over_r,    cjk_over_nxt;
  logic  cjk_hit_r,     cjk_hit_nxt;
  code_t cjk_val_r,     cjk_val_nxt;
  logic  code_done;

  // Result register.
  logic  out_valid_r;
  logic  res_ascii_r;
  logic  res_first_hit_r;
  code_t res_first_val_r;
  logic  res_cjk_hit_r;
  code_t res_cjk_val_r;

  // A non-final byte never needs the output; a final one needs the result slot free.
  assign s1_adv   = s1_valid_r && (!s1_eot_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_text_byte;
      s1_eot_r  <= in_end_of_text;
    end
  end

  always_comb begin
    pending_nxt    = pending_r;
    asm_nxt        = asm_r;
    saw_high_nxt   = saw_high_r | s1_byte_r[ByteW-1];
    first_over_nxt = first_over_r;
    first_hit_nxt  = first_hit_r;
    first_val_nxt  = first_val_r;
    cjk_over_nxt   = cjk_over_r;
    cjk_hit_nxt    = cjk_hit_r;
    cjk_val_nxt    = cjk_val_r;
    code_done      = 1'b0;

    if (pending_r != '0) begin
      if ((s1_byte_r & ContMask) == ContVal) begin
        asm_nxt     = {asm_r[CodeW-7:0], s1_byte_r[5:0]};
        pending_nxt = pending_r - PendOne;
        code_done   = (pending_r == PendOne);
      end else begin
        // Broken sequence: both searches end without a hit.
        first_over_nxt = 1'b1;
        cjk_over_nxt   = 1'b1;
        pending_nxt    = '0;
        asm_nxt        = '0;
      end
    end else if (!s1_byte_r[ByteW-1]) begin
      pending_nxt = '0;
    end else if ((s1_byte_r & Lead2Mask) == Lead2Val) begin
      asm_nxt     = {16'd0, s1_byte_r[4:0]};
      pending_nxt = PendOne;
    end else if ((s1_byte_r & Lead3Mask) == Lead3Val) begin
      asm_nxt     = {17'd0, s1_byte_r[3:0]};
      pending_nxt = PendTwo;
    end else if ((s1_byte_r & Lead4Mask) == Lead4Val) begin
      asm_nxt     = {18'd0, s1_byte_r[2:0]};
      pending_nxt = PendThree;
    end else begin
      // Bad lead byte ends only the non-ASCII search.
      first_over_nxt = 1'b1;
    end

    if (code_done) begin
      if (!first_over_r) begin
        first_hit_nxt  = 1'b1;
        first_val_nxt  = asm_nxt;
        first_over_nxt = 1'b1;
      end
      if (!cjk_over_r && in_cjk_range(asm_nxt)) begin
        cjk_hit_nxt  = 1'b1;
        cjk_val_nxt  = asm_nxt;
        cjk_over_nxt = 1'b1;
      end
    end
  end

  // A truncated sequence at the end only ends searches; the hit flags already hold the answer.
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_eot_r)) begin
      pending_r    <= '0;
      asm_r        <= '0;
      saw_high_r   <= 1'b0;
      first_over_r <= 1'b0;
      first_hit_r  <= 1'b0;
      first_val_r  <= '0;
      cjk_over_r   <= 1'b0;
      cjk_hit_r    <= 1'b0;
      cjk_val_r    <= '0;
    end else if (s1_adv) begin
      pending_r    <= pending_nxt;
      asm_r        <= asm_nxt;
      saw_high_r   <= saw_high_nxt;
      first_over_r <= first_over_nxt;
      first_hit_r  <= first_hit_nxt;
      first_val_r  <= first_val_nxt;
      cjk_over_r   <= cjk_over_nxt;
      cjk_hit_r    <= cjk_hit_nxt;
      cjk_val_r    <= cjk_val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_eot_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_eot_r) begin
      res_ascii_r     <= !saw_high_nxt;
      res_first_hit_r <= first_hit_nxt;
      res_first_val_r <= first_hit_nxt ? first_val_nxt : '0;
      res_cjk_hit_r   <= cjk_hit_nxt;
      res_cjk_val_r   <= cjk_hit_nxt ? cjk_val_nxt : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ascii_only      = res_ascii_r;
  assign out_non_ascii_found = res_first_hit_r;
  assign out_non_ascii_code  = res_first_val_r;
  assign out_cjk_found       = res_cjk_hit_r;
  assign out_cjk_code        = res_cjk_val_r;

  // A multibyte or CJK hit can only come from a text that held high bytes.
  a_cjk_not_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_cjk_hit_r |-> !res_ascii_r)
    else $error("CJK hit reported for an ASCII-only text");

  a_first_not_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_first_hit_r |-> !res_ascii_r)
    else $error("non-ASCII hit reported for an ASCII-only text");

  a_cjk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_cjk_hit_r |-> in_cjk_range(res_cjk_val_r))
    else $error("CJK code outside the CJK ranges");

  a_pending_high: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != '0 |-> saw_high_r)
    else $error("sequence in progress without a high byte seen");

  a_hit_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    (!first_hit_r || first_over_r) && (!cjk_hit_r || cjk_over_r))
    else $error("search still open after a hit");

endmodule
